// ===== rtl/ffha_pkg.sv =====
// shared types, constants and codes for the first-fit heap allocator
// no dependencies
`default_nettype none

package ffha_pkg;

   localparam int WORD_W         = 13;
   localparam int ADDR_W         = 14;
   localparam int NEED_W         = 14;
   localparam int BYTES_W        = 14;
   localparam int DEF_HEAP_WORDS = 4096;
   localparam int DEF_WORD_BYTES = 4;
   localparam int HDR_WORDS      = 2;
   localparam int MIN_SPLIT      = 3;

   localparam logic [WORD_W-1:0] NULL_LINK = 13'h1FFF;

   typedef struct packed {
      logic               mode;
      logic [BYTES_W-1:0] size_bytes;
      logic [WORD_W-1:0]  handle;
   } req_type;

   typedef struct packed {
      logic [WORD_W-1:0] result_handle;
      logic              ok;
   } rsp_type;

   localparam logic MODE_ALLOC = 1'b0;

   typedef enum logic [4:0] {
      ST_CLEAR, ST_IDLE, ST_DECODE, ST_A_NEED, ST_A_CHECK, ST_A_SIZE, ST_A_NEXT,
      ST_S1, ST_S2, ST_S3, ST_S4, ST_S5, ST_S6, ST_S7, ST_T1, ST_T2, ST_FAIL,
      ST_F_RD1, ST_F_RD0, ST_F_NEXT, ST_M_CHECK, ST_M_NEXT, ST_MG2, ST_MG3,
      ST_MG4, ST_PUSH
   } ctrl_state_type;

   typedef enum logic [4:0] {
      CMD_NONE, CMD_CLEAR, CMD_LOAD, CMD_MUL, CMD_NEED, CMD_RD_QSZ, CMD_SIZE,
      CMD_STEP, CMD_RD_LINK, CMD_RD_Q, CMD_SPL_RD, CMD_SPL_W0, CMD_SPL_W1,
      CMD_SPL_W2, CMD_SPL_W3, CMD_SPL_W4, CMD_SPL_W5, CMD_TAKE, CMD_FAIL,
      CMD_F_RD1, CMD_F_RD0, CMD_F_NEXT, CMD_MG_W0, CMD_MG_W1, CMD_MG_LINK,
      CMD_PUSH
   } cmd_type;

   typedef struct packed {
      logic clr_done;
      logic req_alloc;
      logic req_zero;
      logic req_bad;
      logic walk_end;
      logic q_is_pnext;
      logic fits;
      logic split;
      logic contig;
   } status_type;

endpackage

`default_nettype wire

// ===== rtl/ffha_ctrl.sv =====
// sequencing state machine of the heap allocator
// depends on ffha_pkg; drives ffha_dpath through a command code
`default_nettype none

module ffha_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  start,
   input  ffha_pkg::status_type status,
   output ffha_pkg::cmd_type    cmd,
   output logic                 busy
);
   import ffha_pkg::*;

   ctrl_state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

   // next state and command
   always_comb begin
      state_in = state_ff;
      cmd      = CMD_NONE;
      case (state_ff)
         ST_CLEAR: begin
            cmd = CMD_CLEAR;
            if (status.clr_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) begin
               cmd      = CMD_LOAD;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            cmd = CMD_MUL;
            if (status.req_alloc) begin
               state_in = status.req_zero ? ST_FAIL : ST_A_NEED;
            end else begin
               state_in = status.req_bad ? ST_FAIL : ST_F_RD1;
            end
         end
         ST_A_NEED: begin
            cmd      = CMD_NEED;
            state_in = ST_A_CHECK;
         end
         ST_A_CHECK: begin
            if (status.walk_end) begin
               state_in = ST_FAIL;
            end else begin
               cmd      = CMD_RD_QSZ;
               state_in = ST_A_SIZE;
            end
         end
         ST_A_SIZE: begin
            cmd = CMD_SIZE;
            if (status.fits) state_in = status.split ? ST_S1 : ST_T1;
            else             state_in = ST_A_NEXT;
         end
         ST_A_NEXT: begin
            cmd      = CMD_STEP;
            state_in = ST_A_CHECK;
         end
         ST_S1: begin cmd = CMD_SPL_RD;  state_in = ST_S2; end
         ST_S2: begin cmd = CMD_SPL_W0;  state_in = ST_S3; end
         ST_S3: begin cmd = CMD_SPL_W1;  state_in = ST_S4; end
         ST_S4: begin cmd = CMD_SPL_W2;  state_in = ST_S5; end
         ST_S5: begin cmd = CMD_SPL_W3;  state_in = ST_S6; end
         ST_S6: begin cmd = CMD_SPL_W4;  state_in = ST_S7; end
         ST_S7: begin cmd = CMD_SPL_W5;  state_in = ST_T1; end
         ST_T1: begin cmd = CMD_RD_LINK; state_in = ST_T2; end
         ST_T2: begin cmd = CMD_TAKE;    state_in = ST_IDLE; end
         ST_FAIL: begin cmd = CMD_FAIL;  state_in = ST_IDLE; end
         ST_F_RD1: begin cmd = CMD_F_RD1; state_in = ST_F_RD0; end
         ST_F_RD0: begin cmd = CMD_F_RD0; state_in = ST_F_NEXT; end
         ST_F_NEXT: begin
            cmd      = CMD_F_NEXT;
            state_in = status.contig ? ST_M_CHECK : ST_PUSH;
         end
         ST_M_CHECK: begin
            if (status.walk_end) begin
               state_in = ST_PUSH;
            end else if (status.q_is_pnext) begin
               cmd      = CMD_RD_Q;
               state_in = ST_MG2;
            end else begin
               cmd      = CMD_RD_LINK;
               state_in = ST_M_NEXT;
            end
         end
         ST_M_NEXT: begin cmd = CMD_STEP;    state_in = ST_M_CHECK; end
         ST_MG2:    begin cmd = CMD_MG_W0;   state_in = ST_MG3; end
         ST_MG3:    begin cmd = CMD_MG_W1;   state_in = ST_MG4; end
         ST_MG4:    begin cmd = CMD_MG_LINK; state_in = ST_PUSH; end
         ST_PUSH:   begin cmd = CMD_PUSH;    state_in = ST_IDLE; end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/ffha_dpath.sv =====
// datapath of the heap allocator: heap store, walk registers, response
// depends on ffha_pkg; executes the commands of ffha_ctrl
`default_nettype none

module ffha_dpath #(
   parameter int HEAP_WORDS = ffha_pkg::DEF_HEAP_WORDS,
   parameter int WORD_BYTES = ffha_pkg::DEF_WORD_BYTES
) (
   input  wire                  clock,
   input  wire                  reset,
   input  ffha_pkg::cmd_type    cmd,
   input  ffha_pkg::req_type    req_data,
   output ffha_pkg::status_type status,
   output logic                 rsp_valid,
   output ffha_pkg::rsp_type    rsp_data
);
   import ffha_pkg::*;

   localparam int AW          = (HEAP_WORDS > 1) ? $clog2(HEAP_WORDS) : 1;
   localparam int CNT_W       = $clog2(HEAP_WORDS + 1);
   localparam int X_W         = BYTES_W + 1;
   localparam int RECIP_SHIFT = 18;
   localparam int RECIP_MUL   = ((1 << RECIP_SHIFT) + WORD_BYTES - 1) / WORD_BYTES;
   localparam int P_W         = X_W + RECIP_SHIFT;
   localparam logic [ADDR_W-1:0] HEAP_LIM = ADDR_W'(HEAP_WORDS);

   logic [WORD_W-1:0] mem [HEAP_WORDS];
   logic [WORD_W-1:0] rd_q_ff;
   logic              rd_oob_ff;
   logic [WORD_W-1:0] free_head_ff, last_block_ff;
   logic [WORD_W-1:0] q_ff, prev_ff, qsz_ff, p_ff, psz_ff, pnext_ff;
   logic [NEED_W-1:0] need_ff;
   logic [ADDR_W-1:0] nb_ff;
   logic [CNT_W-1:0]  steps_ff, clr_cnt_ff;
   logic [P_W-1:0]    prod_ff;
   req_type           req_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff;

   logic [WORD_W-1:0] rdata, clr_word;
   logic [ADDR_W-1:0] q_x, p_x, prev_x;
   logic [X_W-1:0]    xbytes;
   logic [NEED_W-1:0] need_calc;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_wa, mem_ra;
   logic [WORD_W-1:0] mem_wd;

   assign rdata  = rd_oob_ff ? '0 : rd_q_ff;
   assign q_x    = ADDR_W'(q_ff);
   assign p_x    = ADDR_W'(p_ff);
   assign prev_x = ADDR_W'(prev_ff);

   // word count by reciprocal multiply, rounded up, plus header
   assign xbytes    = X_W'(req_ff.size_bytes) + X_W'(WORD_BYTES - 1);
   assign need_calc = prod_ff[RECIP_SHIFT +: NEED_W] + NEED_W'(HDR_WORDS);

   // status toward the controller
   always_comb begin
      status.clr_done   = (clr_cnt_ff == CNT_W'(HEAP_WORDS - 1));
      status.req_alloc  = (req_ff.mode == MODE_ALLOC);
      status.req_zero   = (req_ff.size_bytes == '0);
      status.req_bad    = (req_ff.handle == NULL_LINK)
                          || (req_ff.handle < WORD_W'(HDR_WORDS))
                          || ((ADDR_W'(req_ff.handle) - ADDR_W'(HDR_WORDS)) >= HEAP_LIM);
      status.walk_end   = (q_x >= HEAP_LIM) || (steps_ff >= CNT_W'(HEAP_WORDS));
      status.q_is_pnext = (q_ff == pnext_ff);
      status.fits       = (NEED_W'(rdata) >= need_ff);
      status.split      = (NEED_W'(rdata) >= need_ff + NEED_W'(MIN_SPLIT));
      status.contig     = ((p_x + ADDR_W'(psz_ff)) == ADDR_W'(rdata));
   end

   // initial header words written by the clearing pass
   always_comb begin
      case (clr_cnt_ff)
         CNT_W'(0): clr_word = NULL_LINK;
         CNT_W'(1): clr_word = WORD_W'(HEAP_WORDS);
         CNT_W'(2): clr_word = NULL_LINK;
         default:   clr_word = '0;
      endcase
   end

   // store port selection
   always_comb begin
      mem_we = 1'b0;
      mem_wa = '0;
      mem_wd = '0;
      mem_ra = q_x + ADDR_W'(2);
      case (cmd)
         CMD_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = ADDR_W'(clr_cnt_ff);
            mem_wd = clr_word;
         end
         CMD_RD_QSZ: mem_ra = q_x + ADDR_W'(1);
         CMD_RD_Q, CMD_SPL_RD: mem_ra = q_x;
         CMD_SPL_W0: begin
            mem_we = 1'b1; mem_wa = nb_ff; mem_wd = rdata;
         end
         CMD_SPL_W1: begin
            mem_we = 1'b1; mem_wa = q_x; mem_wd = nb_ff[WORD_W-1:0];
         end
         CMD_SPL_W2: begin
            mem_we = 1'b1;
            mem_wa = nb_ff + ADDR_W'(1);
            mem_wd = WORD_W'(NEED_W'(qsz_ff) - need_ff);
         end
         CMD_SPL_W3: begin
            mem_we = 1'b1; mem_wa = q_x + ADDR_W'(1); mem_wd = WORD_W'(need_ff);
         end
         CMD_SPL_W4: begin
            mem_we = 1'b1; mem_wa = nb_ff + ADDR_W'(2); mem_wd = rdata;
         end
         CMD_SPL_W5: begin
            mem_we = 1'b1; mem_wa = q_x + ADDR_W'(2); mem_wd = nb_ff[WORD_W-1:0];
         end
         CMD_TAKE, CMD_MG_LINK: begin
            mem_we = (prev_ff != NULL_LINK);
            mem_wa = prev_x + ADDR_W'(2);
            mem_wd = rdata;
         end
         CMD_F_RD1: mem_ra = p_x + ADDR_W'(1);
         CMD_F_RD0: mem_ra = p_x;
         CMD_MG_W0: begin
            mem_we = 1'b1; mem_wa = p_x; mem_wd = rdata;
            mem_ra = q_x + ADDR_W'(1);
         end
         CMD_MG_W1: begin
            mem_we = 1'b1; mem_wa = p_x + ADDR_W'(1); mem_wd = psz_ff + rdata;
         end
         CMD_PUSH: begin
            mem_we = 1'b1; mem_wa = p_x + ADDR_W'(2); mem_wd = free_head_ff;
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   // heap store, writes beyond the heap are dropped, reads there give zero
   always_ff @(posedge clock) begin
      if (mem_we && (mem_wa < HEAP_LIM)) begin
         mem[mem_wa[AW-1:0]] <= mem_wd;
      end
      rd_q_ff   <= mem[mem_ra[AW-1:0]];
      rd_oob_ff <= (mem_ra >= HEAP_LIM);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         free_head_ff  <= '0;
         last_block_ff <= '0;
         clr_cnt_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= (cmd == CMD_TAKE) || (cmd == CMD_FAIL) || (cmd == CMD_PUSH);
         case (cmd)
            CMD_CLEAR: clr_cnt_ff <= clr_cnt_ff + CNT_W'(1);
            CMD_SPL_W3: begin
               if (last_block_ff == q_ff) last_block_ff <= nb_ff[WORD_W-1:0];
            end
            CMD_TAKE: begin
               if (prev_ff == NULL_LINK) free_head_ff <= rdata;
            end
            CMD_MG_LINK: begin
               if (prev_ff == NULL_LINK) free_head_ff <= rdata;
               if (last_block_ff == q_ff) last_block_ff <= p_ff;
            end
            CMD_PUSH: free_head_ff <= p_ff;
            default: begin
               clr_cnt_ff <= clr_cnt_ff;
            end
         endcase
      end
   end

   // walk and request registers
   always_ff @(posedge clock) begin
      case (cmd)
         CMD_LOAD: begin
            req_ff <= req_data;
            p_ff   <= req_data.handle - WORD_W'(HDR_WORDS);
         end
         CMD_MUL: prod_ff <= P_W'(xbytes) * P_W'(RECIP_MUL);
         CMD_NEED: begin
            need_ff  <= need_calc;
            q_ff     <= free_head_ff;
            prev_ff  <= NULL_LINK;
            steps_ff <= '0;
         end
         CMD_SIZE: qsz_ff <= rdata;
         CMD_STEP: begin
            prev_ff  <= q_ff;
            q_ff     <= rdata;
            steps_ff <= steps_ff + CNT_W'(1);
         end
         CMD_SPL_RD: nb_ff <= q_x + ADDR_W'(need_ff);
         CMD_F_RD0:  psz_ff <= rdata;
         CMD_F_NEXT: begin
            pnext_ff <= rdata;
            q_ff     <= free_head_ff;
            prev_ff  <= NULL_LINK;
            steps_ff <= '0;
         end
         CMD_TAKE: begin
            rsp_ff.result_handle <= WORD_W'(q_x + ADDR_W'(2));
            rsp_ff.ok            <= 1'b1;
         end
         CMD_FAIL: begin
            rsp_ff.result_handle <= NULL_LINK;
            rsp_ff.ok            <= 1'b0;
         end
         CMD_PUSH: begin
            rsp_ff.result_handle <= NULL_LINK;
            rsp_ff.ok            <= 1'b1;
         end
         default: begin
            q_ff <= q_ff;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// ===== rtl/first_fit_heap_allocator.sv =====
// top level of the first-fit heap allocator
// depends on ffha_pkg, ffha_ctrl and ffha_dpath
//
//   channel   ports                     handshake
//   request   start, busy, req_data     taken when start high and busy low
//   response  rsp_valid, rsp_data       one-cycle strobe, cannot be held off
//
// after reset a clearing pass writes the whole store while busy is high
// allocate: decode, word count, then a size read and compare per free-list block, split writes on a split, unlink
// free: read size and link of the block; when the next block is contiguous, search the free list
// for it and merge it when found; then push the block at the list head
// zero-size allocate or ignored free: straight to the failure response
// the store has one read and one write port, so every walk step costs a read
// busy drops in the cycle the response strobe shows; a new request may enter then
`default_nettype none

module first_fit_heap_allocator #(
   parameter int HEAP_WORDS = ffha_pkg::DEF_HEAP_WORDS,
   parameter int WORD_BYTES = ffha_pkg::DEF_WORD_BYTES
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                start,
   output logic               busy,
   input  ffha_pkg::req_type  req_data,
   output logic               rsp_valid,
   output ffha_pkg::rsp_type  rsp_data
);
   import ffha_pkg::*;

   cmd_type    cmd;
   status_type status;

   // sequencer
   ffha_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   // store and registers
   ffha_dpath #(
      .HEAP_WORDS (HEAP_WORDS),
      .WORD_BYTES (WORD_BYTES)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ===== rtl/ffha_checker.sv =====
// port-level checks of the heap allocator, bound to the top level
// depends on ffha_pkg and first_fit_heap_allocator
`default_nettype none

module ffha_checker (
   input wire               clock,
   input wire               reset,
   input wire               start,
   input wire               busy,
   input wire               rsp_valid,
   input ffha_pkg::rsp_type rsp_data
);
   import ffha_pkg::*;

   // an accepted request keeps the block busy next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("not busy after request");

   // no response directly after an accept
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> !rsp_valid) else $error("response too early");

   // responses are single strobes and come with the block idle
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("response strobe too long");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("response while busy");

   // a real handle always means success
   a_handle_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.result_handle != NULL_LINK)) |-> rsp_data.ok)
      else $error("handle without ok");

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

`default_nettype wire

// ===== dv/tb_first_fit_heap_allocator.sv =====
// self-checking testbench for first_fit_heap_allocator: directed and random
// allocate/free requests against a built-in heap predictor
// depends on ffha_pkg and the first_fit_heap_allocator rtl
`default_nettype none

module tb_first_fit_heap_allocator;
   import ffha_pkg::*;

   localparam int HEAP      = DEF_HEAP_WORDS;
   localparam int WBYTES    = DEF_WORD_BYTES;
   localparam int MAX_CYC   = 100000000;
   localparam logic MODE_FREE = ~MODE_ALLOC;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   first_fit_heap_allocator dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   // heap predictor state
   logic [WORD_W-1:0] heap_words [HEAP];
   int unsigned       free_head_m;
   int unsigned       last_blk_m;

   rsp_type           pending_results[$];
   logic [WORD_W-1:0] live_handles[$];
   int                fail_count = 0;
   int unsigned       cycle_count = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------- predictor ----------------
   function automatic int unsigned hp_rd(int unsigned a);
      return (a < HEAP) ? int'(heap_words[a]) : 0;
   endfunction

   function automatic void hp_wr(int unsigned a, int unsigned v);
      if (a < HEAP) heap_words[a] = v[WORD_W-1:0];
   endfunction

   function automatic void set_link(int unsigned prev, int unsigned v);
      if (prev == NULL_LINK) free_head_m = v & 13'h1FFF;
      else hp_wr(prev + 2, v);
   endfunction

   function automatic void heap_reset();
      for (int i = 0; i < HEAP; i++) heap_words[i] = '0;
      hp_wr(0, NULL_LINK);
      hp_wr(1, HEAP);
      hp_wr(2, NULL_LINK);
      free_head_m = 0;
      last_blk_m  = 0;
   endfunction

   // first-fit allocate, returns user word address or null
   function automatic int unsigned heap_alloc(int unsigned bytes);
      int unsigned need, prev, q, steps, qsz, nb;
      prev  = NULL_LINK;
      q     = free_head_m;
      steps = 0;
      if (bytes == 0) return NULL_LINK;
      need = (bytes + WBYTES - 1) / WBYTES + HDR_WORDS;
      while (q < HEAP && steps < HEAP) begin
         qsz = hp_rd(q + 1);
         if (qsz >= need) begin
            if (qsz >= need + MIN_SPLIT) begin
               nb = q + need;
               hp_wr(nb, hp_rd(q));
               hp_wr(q, nb);
               hp_wr(nb + 1, qsz - need);
               hp_wr(q + 1, need);
               if (last_blk_m == q) last_blk_m = nb & 13'h1FFF;
               hp_wr(nb + 2, hp_rd(q + 2));
               hp_wr(q + 2, nb);
            end
            set_link(prev, hp_rd(q + 2));
            return (q + 2) & 13'h1FFF;
         end
         prev = q;
         q    = hp_rd(q + 2);
         steps++;
      end
      return NULL_LINK;
   endfunction

   // free with forward merge, then push at list head
   function automatic void heap_free(int unsigned p);
      int unsigned psz, pnext, prev, q, steps;
      psz   = hp_rd(p + 1);
      pnext = hp_rd(p);
      if (p + psz == pnext) begin
         prev  = NULL_LINK;
         q     = free_head_m;
         steps = 0;
         while (q < HEAP && steps < HEAP) begin
            if (q == pnext) begin
               hp_wr(p, hp_rd(q));
               hp_wr(p + 1, psz + hp_rd(q + 1));
               set_link(prev, hp_rd(q + 2));
               if (last_blk_m == q) last_blk_m = p;
               break;
            end
            prev = q;
            q    = hp_rd(q + 2);
            steps++;
         end
      end
      hp_wr(p + 2, free_head_m);
      free_head_m = p;
   endfunction

   function automatic rsp_type predict_request(req_type r);
      rsp_type o;
      int unsigned h;
      o.result_handle = NULL_LINK;
      o.ok            = 1'b0;
      h = r.handle;
      if (r.mode == MODE_ALLOC) begin
         o.result_handle = WORD_W'(heap_alloc(r.size_bytes));
         o.ok            = (o.result_handle != NULL_LINK);
      end else if (h != NULL_LINK && h >= 2 && (h - 2) < HEAP) begin
         heap_free(h - 2);
         o.ok = 1'b1;
      end
      return o;
   endfunction

   // ---------------- response checker ----------------
   always @(posedge clock) begin
      rsp_type exp_r;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected response handle=%0d ok=%0d",
                     $time, rsp_data.result_handle, rsp_data.ok);
            fail_count++;
         end else begin
            exp_r = pending_results.pop_front();
            if (rsp_data.result_handle !== exp_r.result_handle) begin
               $display("%0t: result_handle expected %0d actual %0d",
                        $time, exp_r.result_handle, rsp_data.result_handle);
               fail_count++;
            end
            if (rsp_data.ok !== exp_r.ok) begin
               $display("%0t: ok expected %0d actual %0d",
                        $time, exp_r.ok, rsp_data.ok);
               fail_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > MAX_CYC) begin
         $display("FAIL");
         $finish;
      end
   end

   // ---------------- request driving ----------------
   bit no_gaps = 1'b0;

   task automatic issue_request(logic m, logic [BYTES_W-1:0] sz, logic [WORD_W-1:0] h);
      req_type r;
      rsp_type o;
      r.mode       = m;
      r.size_bytes = sz;
      r.handle     = h;
      @(negedge clock);
      start    <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      o = predict_request(r);
      pending_results.push_back(o);
      if (m == MODE_ALLOC && o.ok) live_handles.push_back(o.result_handle);
   endtask

   task automatic idle_gap();
      int unsigned sel, n;
      sel = $urandom_range(0, 99);
      if (no_gaps || sel < 50) n = 0;
      else if (sel < 90) n = $urandom_range(1, 3);
      else n = $urandom_range(10, 40);
      if (n > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (n - 1) @(negedge clock);
      end
   endtask

   task automatic do_alloc(logic [BYTES_W-1:0] sz);
      issue_request(MODE_ALLOC, sz, $urandom);
      idle_gap();
   endtask

   task automatic do_free(logic [WORD_W-1:0] h);
      issue_request(MODE_FREE, $urandom, h);
      idle_gap();
   endtask

   task automatic free_live(int idx);
      logic [WORD_W-1:0] h;
      h = live_handles[idx];
      live_handles.delete(idx);
      do_free(h);
   endtask

   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   // ---------------- tests ----------------
   task automatic test_edge_cases();
      do_alloc(0);                          // zero size
      do_alloc(14'h3FFF);                   // larger than heap
      do_free(NULL_LINK);                   // null handle
      do_free(0);                           // below heap
      do_free(1);
      do_free(13'd4098);                    // block past heap end
      do_free(13'd8190);
      do_alloc((HEAP - HDR_WORDS) * WBYTES); // exact fit of whole heap
      do_alloc(1);                          // nothing left
      free_live(0);
   endtask

   task automatic test_split_and_merge();
      do_alloc(1);
      do_alloc(5);
      do_alloc(8);
      do_alloc(12);                         // remainder is large enough to split again
      free_live(1);
      free_live(0);                         // merges with following free block
      do_alloc(3);
      do_alloc(7);
      while (live_handles.size() != 0) free_live(live_handles.size() - 1);
   endtask

   task automatic test_random_traffic(int n_items);
      int unsigned sel;
      logic [BYTES_W-1:0] sz;
      for (int i = 0; i < n_items; i++) begin
         if (i % 100 == 0) no_gaps = ($urandom_range(0, 3) == 0);
         if (i % 250 == 125) drain();      // hold off until all responses are in
         sel = $urandom_range(0, 99);
         if (sel < 55 || live_handles.size() == 0) begin
            case ($urandom_range(0, 19))
               0:       sz = $urandom;        // any size, often failing
               1:       sz = $urandom_range(400, 4000);
               2:       sz = 0;
               default: sz = $urandom_range(1, 64);
            endcase
            do_alloc(sz);
         end else if (sel < 93) begin
            free_live($urandom_range(0, live_handles.size() - 1));
         end else begin
            // ignored frees: null, below heap, beyond heap
            case ($urandom_range(0, 2))
               0: do_free(NULL_LINK);
               1: do_free($urandom_range(0, 1));
               default: do_free($urandom_range(HEAP + 2, 8190));
            endcase
         end
      end
   endtask

   // unchecked frees last, since they may corrupt the heap
   task automatic test_bad_frees();
      logic [WORD_W-1:0] h;
      do_alloc(20);
      h = live_handles[live_handles.size() - 1];
      do_free(h);
      do_free(h);                           // double free
      for (int i = 0; i < 40; i++) begin
         if ($urandom_range(0, 1)) do_free($urandom_range(2, HEAP + 1));
         else do_alloc($urandom_range(1, 200));
      end
   endtask

   initial begin
      start    = 1'b0;
      req_data = '0;
      reset    = 1'b1;
      heap_reset();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_edge_cases();
      test_split_and_merge();
      test_random_traffic(1000);
      test_bad_frees();

      drain();
      repeat (200) @(posedge clock);
      if (fail_count == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule

`default_nettype wire
